[rtl/rate_of_rise_tracker_defines.svh]
// Assertion macros shared by the rate-of-rise tracker modules.
`ifndef RATE_OF_RISE_TRACKER_DEFINES_SVH
`define RATE_OF_RISE_TRACKER_DEFINES_SVH

// Concurrent assertion with an implication, disabled during reset.
`define ROR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Concurrent assertion with a next-cycle implication, disabled during reset.
`define ROR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/ror_pkg.sv]
`default_nettype none
package ror_pkg;

    localparam int TIME_W   = 32;
    localparam int TEMP_W   = 16;
    localparam int SPAN_W   = 20;
    localparam int SMOOTH_W = 16;
    localparam int RISE_W   = 32;
    localparam int CNT_W    = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 1'd1;

    localparam logic [SPAN_W-1:0]   SPAN_RESET   = 20'd20000;
    localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 16'd2000;

    // Milliseconds per minute.
    localparam logic [15:0] MS_PER_MIN = 16'd60000;

    typedef struct packed {
        logic [TIME_W-1:0]        sample_time_ms;
        logic signed [TEMP_W-1:0] temperature;
    } in_item_t;

    typedef struct packed {
        logic signed [RISE_W-1:0] rise_per_minute;
        logic                     fresh;
        logic [CNT_W-1:0]         averaged_count;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store request and write it to history
        logic scan_start;  // clear scan index
        logic scan_step;   // present a history entry read
        logic anchor_eval; // evaluate read entry for anchor
        logic win_eval;    // evaluate read entry for window
        logic prep;        // form numerator and denominator
        logic mul_step;    // numerator multiply stage
        logic div_start;
        logic div_step;
        logic finish;      // saturate and load result
        logic hold;        // load held result
    } ror_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;   // current index is the last stored entry
        logic anchor_hit;  // evaluated entry qualifies as anchor
        logic win_break;   // evaluated entry ends the window scan
        logic zero_elapsed;
        logic div_done;
    } ror_sts_t;

endpackage
`default_nettype wire

[rtl/ror_ctrl.sv]
`default_nettype none
`include "rate_of_rise_tracker_defines.svh"
module ror_ctrl
    import ror_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  wire logic     out_stall,
    output ror_cmd_t      cmd,
    input  wire ror_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_A_RD, ST_A_EV, ST_ELAP, ST_W_RD, ST_W_EV,
        ST_PREP, ST_MUL, ST_DIV, ST_FIN, ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Accept a new request when idle and the output slot is free or freeing.
    logic accept;
    assign in_stall  = !(state_reg == ST_IDLE && (!out_valid_reg || !out_stall));
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load       = 1'b1;
                    cmd.scan_start = 1'b1;
                    state_next     = ST_A_RD;
                end
            end
            ST_A_RD:
            begin
                cmd.scan_step = 1'b1;
                state_next    = ST_A_EV;
            end
            ST_A_EV:
            begin
                cmd.anchor_eval = 1'b1;
                if (sts.anchor_hit)
                begin
                    state_next = ST_ELAP;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_OUT;
                    cmd.hold   = 1'b1;
                end
                else
                begin
                    state_next = ST_A_RD;
                end
            end
            ST_ELAP:
            begin
                if (sts.zero_elapsed)
                begin
                    cmd.hold   = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_W_RD;
                end
            end
            ST_W_RD:
            begin
                cmd.scan_step = 1'b1;
                state_next    = ST_W_EV;
            end
            ST_W_EV:
            begin
                cmd.win_eval = 1'b1;
                if (sts.win_break || sts.scan_last)
                begin
                    state_next = ST_PREP;
                end
                else
                begin
                    state_next = ST_W_RD;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_step  = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered output flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A request is taken only in the idle state.
    `ROR_ASSERT_IMPL(a_accept_idle, accept, state_reg == ST_IDLE)
    // An accepted request always starts the anchor scan.
    `ROR_ASSERT_NEXT(a_accept_scan, accept, state_reg == ST_A_RD)
    // A result is raised only when leaving the output state.
    `ROR_ASSERT_NEXT(a_out_from_out, state_reg == ST_OUT && out_valid_next && !out_valid_reg,
        out_valid_reg && state_reg == ST_IDLE)

endmodule
`default_nettype wire

[rtl/ror_div.sv]
`default_nettype none
// Restoring divider of unsigned magnitudes, one quotient bit per cycle.
module ror_div
    import ror_pkg::*;
#(
    parameter int NUM_W = 58,
    parameter int DEN_W = 45
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             step,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0]      quot,
    output logic                  done
);

    localparam int CNT_DW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  quot_reg, quot_next;
    logic [DEN_W:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [CNT_DW-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]    trial;

    assign trial = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};

    // One shift-subtract iteration.
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            quot_next = num;
            rem_next  = '0;
            cnt_next  = CNT_DW'(NUM_W);
        end
        else if (step && cnt_reg != '0)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quot = quot_reg;
    assign done = (cnt_reg == '0);

endmodule
`default_nettype wire

[rtl/ror_dp.sv]
`default_nettype none
`include "rate_of_rise_tracker_defines.svh"
module ror_dp
    import ror_pkg::*;
#(
    parameter int HISTORY_DEPTH = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ror_cmd_t              cmd,
    output ror_sts_t                   sts,
    input  wire in_item_t              req,
    input  wire logic [SPAN_W-1:0]     span_ms,
    input  wire logic [SMOOTH_W-1:0]   smooth_ms,
    output out_item_t                  result
);

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_HW = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W = TEMP_W + CNT_HW + 1;
    localparam int NUM_W = SUM_W + 17;
    localparam int DEN_W = TIME_W + CNT_HW;
    localparam logic [PTR_W-1:0]  PTR_MAX = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_HW-1:0] DEPTH_C = CNT_HW'(HISTORY_DEPTH);

    // History memory.
    logic [TIME_W-1:0]        mem_time [HISTORY_DEPTH];
    logic signed [TEMP_W-1:0] mem_temp [HISTORY_DEPTH];
    logic [TIME_W-1:0]        rd_time_reg;
    logic signed [TEMP_W-1:0] rd_temp_reg;

    logic [PTR_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [CNT_HW-1:0] stored_reg, stored_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_HW-1:0] scan_j_reg;
    logic [TIME_W-1:0]        now_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic [TIME_W-1:0]        anchor_time_reg;
    logic signed [TEMP_W-1:0] anchor_temp_reg;
    logic [TIME_W-1:0]        elapsed_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CNT_HW-1:0]        n_reg;
    logic signed [RISE_W-1:0] held_reg;
    logic                     fresh_reg;
    logic [CNT_W-1:0]         count_out_reg;
    logic signed [SUM_W+1:0]  diff_reg;
    logic [CNT_HW-1:0]        n_eff_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     neg_reg;
    logic [NUM_W-1:0]         quot;
    logic                     div_done;
    logic signed [RISE_W-1:0] result_sat;

    function automatic logic [PTR_W-1:0] rd_ptr_dec(input logic [PTR_W-1:0] p);
        rd_ptr_dec = (p == '0) ? PTR_MAX : p - 1'b1;
    endfunction

    // Write pointer and fill count.
    always_comb
    begin
        wr_pos_next = wr_pos_reg;
        stored_next = stored_reg;
        if (cmd.load)
        begin
            wr_pos_next = (wr_pos_reg == PTR_MAX) ? '0 : wr_pos_reg + 1'b1;
            if (stored_reg != DEPTH_C)
            begin
                stored_next = stored_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_pos_reg <= '0;
            stored_reg <= '0;
            held_reg   <= '0;
        end
        else
        begin
            wr_pos_reg <= wr_pos_next;
            stored_reg <= stored_next;
            if (cmd.finish)
            begin
                held_reg <= result_sat;
            end
        end
    end

    // Memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem_time[wr_pos_reg] <= req.sample_time_ms;
            mem_temp[wr_pos_reg] <= req.temperature;
        end
        if (cmd.scan_step)
        begin
            rd_time_reg <= mem_time[rd_ptr_reg];
            rd_temp_reg <= mem_temp[rd_ptr_reg];
        end
    end

    // Scan pointer walks from newest to oldest. After the load the newest
    // entry sits one below the write pointer.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg  <= req.sample_time_ms;
            temp_reg <= req.temperature;
        end
        if (cmd.scan_start)
        begin
            rd_ptr_reg <= cmd.load ? wr_pos_reg : rd_ptr_dec(wr_pos_reg);
            scan_j_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            rd_ptr_reg <= rd_ptr_dec(rd_ptr_reg);
            scan_j_reg <= scan_j_reg + 1'b1;
        end
    end

    // Evaluation of the entry just read.
    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] d;
    logic [TIME_W-1:0] mag;
    logic              d_neg;
    logic              in_win;
    assign age   = now_reg - rd_time_reg;
    assign d     = rd_time_reg - anchor_time_reg;
    assign mag   = 32'd0 - d;
    assign d_neg = d[TIME_W-1];
    assign in_win = d_neg ? (mag <= {16'd0, smooth_ms} && d != 32'h8000_0000)
                          : (d <= {16'd0, smooth_ms});

    assign sts.scan_last  = (scan_j_reg == stored_reg);
    assign sts.anchor_hit = (age >= {12'd0, span_ms});
    assign sts.win_break  = d_neg && !in_win;
    assign sts.zero_elapsed = (elapsed_reg == '0);
    assign sts.div_done   = div_done;

    always_ff @(posedge clk)
    begin
        if (cmd.anchor_eval && sts.anchor_hit)
        begin
            anchor_time_reg <= rd_time_reg;
            anchor_temp_reg <= rd_temp_reg;
            elapsed_reg     <= age;
        end
        if (cmd.scan_start && !cmd.load)
        begin
            sum_reg <= '0;
            n_reg   <= '0;
        end
        else if (cmd.win_eval && in_win)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_temp_reg);
            n_reg   <= n_reg + 1'b1;
        end
    end

    // Numerator n*new - sum, then the scale by 60000 and the denominator.
    logic [CNT_HW-1:0]       n_use;
    logic signed [SUM_W-1:0] s_use;
    assign n_use = (n_reg == '0) ? CNT_HW'(1) : n_reg;
    assign s_use = (n_reg == '0) ? SUM_W'(anchor_temp_reg) : sum_reg;

    logic signed [SUM_W+1:0] n_ext;
    logic signed [SUM_W+1:0] t_ext;
    assign n_ext = (SUM_W+2)'($signed({1'b0, n_use}));
    assign t_ext = (SUM_W+2)'(temp_reg);

    logic signed [SUM_W+1:0] diff_abs;
    assign diff_abs = diff_reg[SUM_W+1] ? -diff_reg : diff_reg;

    logic [NUM_W-1:0] num_mag;
    assign num_mag = NUM_W'(diff_abs[SUM_W:0]) * NUM_W'(MS_PER_MIN);

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            diff_reg  <= n_ext * t_ext - (SUM_W+2)'(s_use);
            n_eff_reg <= n_use;
            den_reg   <= DEN_W'(n_use) * DEN_W'(elapsed_reg);
        end
        if (cmd.mul_step)
        begin
            neg_reg <= diff_reg[SUM_W+1];
        end
    end

    // Long division of the magnitudes.
    ror_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .step  (cmd.div_step),
        .num   (num_mag),
        .den   (den_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // Sign restore and saturation.
    always_comb
    begin
        if (!neg_reg)
        begin
            result_sat = (quot > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                        : RISE_W'(quot);
        end
        else
        begin
            result_sat = (quot > NUM_W'(33'h8000_0000)) ? 32'sh8000_0000
                                                        : RISE_W'(-quot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            fresh_reg     <= 1'b1;
            count_out_reg <= CNT_W'(n_eff_reg);
        end
        else if (cmd.hold)
        begin
            fresh_reg     <= 1'b0;
            count_out_reg <= '0;
        end
    end

    assign result.rise_per_minute = cmd.finish ? result_sat : held_reg;
    assign result.fresh           = fresh_reg;
    assign result.averaged_count  = count_out_reg;

    // Fill count never exceeds the depth.
    `ROR_ASSERT_IMPL(a_fill_bound, 1'b1, stored_reg <= DEPTH_C)
    // Loading a request advances the fill count unless full.
    `ROR_ASSERT_NEXT(a_fill_step, cmd.load && stored_reg != DEPTH_C,
        stored_reg == $past(stored_reg) + 1'b1)
    // A held result never reports averaged samples.
    `ROR_ASSERT_NEXT(a_hold_count, cmd.hold, !fresh_reg && count_out_reg == '0)

endmodule
`default_nettype wire

[rtl/rate_of_rise_tracker.sv]
// Rate-of-rise tracker. Each accepted sample is written to a history ring, then
// history entries are read one at a time from newest to oldest to find the anchor
// (newest sample at least span_ms old), then again to average the samples within
// smooth_ms of it, and a restoring divider produces one quotient bit per cycle.
// The scan over the single-port history memory and the serial divider set how long
// one request takes. A held result (fresh low) is reported when no anchor exists
// yet or the elapsed time to it is zero. Configuration must be written only while
// idle; the block itself does not enforce it.
`default_nettype none
module rate_of_rise_tracker
    import ror_pkg::*;
#(
    parameter int HISTORY_DEPTH = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    ror_cmd_t  cmd;
    ror_sts_t  sts;
    out_item_t result;
    logic [SPAN_W-1:0]   span_reg;
    logic [SMOOTH_W-1:0] smooth_reg;
    logic signed [RISE_W-1:0] rise_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg   <= SPAN_RESET;
            smooth_reg <= SMOOTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SPAN:   span_reg   <= cfg_data[SPAN_W-1:0];
                REG_SMOOTH: smooth_reg <= cfg_data[SMOOTH_W-1:0];
                default:    span_reg   <= span_reg;
            endcase
        end
    end

    ror_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    ror_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (in_data),
        .span_ms   (span_reg),
        .smooth_ms (smooth_reg),
        .result    (result)
    );

    // Result rate register, loaded on fresh or held results.
    always_ff @(posedge clk)
    begin
        if (cmd.finish || cmd.hold)
        begin
            rise_reg <= result.rise_per_minute;
        end
    end

    assign out_data.rise_per_minute = rise_reg;
    assign out_data.fresh           = result.fresh;
    assign out_data.averaged_count  = result.averaged_count;

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
module tb;
    import ror_pkg::*;

    localparam int DEPTH = 256;
    localparam int HOLD_CYCLES = 3000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SPAN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    rate_of_rise_tracker dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Clock with period 4.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state: sample history, ring pointer, fill level and held rise.
    logic [31:0] hist_time [DEPTH];
    logic signed [15:0] hist_temp [DEPTH];
    int ring_pos = 0;
    int fill = 0;
    logic signed [31:0] held_rise = '0;
    logic [SPAN_W-1:0] span_cfg = SPAN_RESET;
    logic [SMOOTH_W-1:0] smooth_cfg = SMOOTH_RESET;

    in_item_t pending_samples[$];
    out_item_t rise_expect_q[$];
    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int samples_taken = 0;
    int rises_seen = 0;
    int fresh_seen = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    logic in_taken = 1'b0;

    // Stimulus generator state.
    logic [31:0] clock_ms = '0;
    int temp_now = 0;

    // Store the sample, find the anchor, average its window and form the rise.
    function automatic out_item_t predict_rise(input in_item_t smp);
        out_item_t res;
        logic [31:0] now, age, d, mag, elapsed;
        int idx, anchor, n;
        bit found;
        longint sum, num, den, q;
        now = smp.sample_time_ms;
        hist_time[ring_pos] = now;
        hist_temp[ring_pos] = smp.temperature;
        ring_pos = (ring_pos + 1) % DEPTH;
        if (fill < DEPTH)
            fill++;
        found = 1'b0;
        anchor = 0;
        n = 0;
        sum = 0;
        for (int j = 0; j < fill; j++)
        begin
            idx = (ring_pos + DEPTH - 1 - j) % DEPTH;
            age = now - hist_time[idx];
            if (age >= {12'd0, span_cfg})
            begin
                anchor = idx;
                found = 1'b1;
                break;
            end
        end
        elapsed = now - hist_time[anchor];
        res.fresh = 1'b0;
        res.averaged_count = '0;
        res.rise_per_minute = held_rise;
        if (!found || elapsed == 32'd0)
            return res;
        for (int j = 0; j < fill; j++)
        begin
            idx = (ring_pos + DEPTH - 1 - j) % DEPTH;
            d = hist_time[idx] - hist_time[anchor];
            if (!d[31])
            begin
                if (d > {16'd0, smooth_cfg})
                    continue;
            end
            else
            begin
                mag = 32'd0 - d;
                if (d == 32'h8000_0000 || mag > {16'd0, smooth_cfg})
                    break;
            end
            sum += hist_temp[idx];
            n++;
        end
        if (n == 0)
        begin
            sum = hist_temp[anchor];
            n = 1;
        end
        num = (longint'(n) * smp.temperature - sum) * 60000;
        den = longint'(n) * longint'({32'd0, elapsed});
        q = num / den;
        if (q > 64'sd2147483647)
            q = 64'sd2147483647;
        else if (q < -64'sd2147483648)
            q = -64'sd2147483648;
        held_rise = q[31:0];
        res.rise_per_minute = held_rise;
        res.fresh = 1'b1;
        res.averaged_count = n[CNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Record acceptance of requests and predict their results.
    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            rise_expect_q.push_back(predict_rise(in_data));
            samples_taken++;
        end
    end

    // Driver: offer the next pending sample once the current one is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_data <= pending_samples.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, counted here.
    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    always @(negedge clk)
        out_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);

    // Monitor: compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            rises_seen++;
            if (rise_expect_q.size() == 0)
                report_mismatch("result with nothing expected", 1, 0);
            else
            begin
                want = rise_expect_q.pop_front();
                if (out_data.fresh)
                    fresh_seen++;
                if (out_data.rise_per_minute !== want.rise_per_minute)
                    report_mismatch("rise_per_minute", out_data.rise_per_minute,
                                    want.rise_per_minute);
                if (out_data.fresh !== want.fresh)
                    report_mismatch("fresh", out_data.fresh, want.fresh);
                if (out_data.averaged_count !== want.averaged_count)
                    report_mismatch("averaged_count", out_data.averaged_count,
                                    want.averaged_count);
            end
        end
    end

    task automatic add_sample(input logic [31:0] t, input int temp);
        in_item_t smp;
        smp.sample_time_ms = t;
        smp.temperature = temp[15:0];
        pending_samples.push_back(smp);
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || in_valid || rise_expect_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SPAN)
            span_cfg = val[SPAN_W-1:0];
        else
            smooth_cfg = val[SMOOTH_W-1:0];
    endtask

    // A stream of samples: mostly regular steps, some duplicates, jumps and noise.
    task automatic queue_stream(input int count, input int jump_pct);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < jump_pct)
                clock_ms += $urandom_range(1000, 1200000);
            else if (r < jump_pct + 6)
                clock_ms += $urandom_range(0, 3);
            else if (r < jump_pct + 8)
                clock_ms = $urandom;
            else if (r < jump_pct + 10)
                clock_ms -= $urandom_range(1, 5000);
            else
                clock_ms += $urandom_range(50, 200);
            r = $urandom_range(0, 99);
            if (r < 4)
                temp_now = $signed(16'($urandom));
            else
                temp_now += $urandom_range(0, 80) - 40;
            if (temp_now > 32767)
                temp_now = 32767;
            if (temp_now < -32768)
                temp_now = -32768;
            add_sample(clock_ms, temp_now);
        end
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: default registers, duplicate and wrapping times, extremes.
        add_sample(32'd0, -32768);
        add_sample(32'd0, 32767);
        add_sample(32'd1500, 0);
        add_sample(32'd20000, 32767);
        add_sample(32'd20001, -32768);
        add_sample(32'd22500, 100);
        add_sample(32'hFFFF_FFFF, -1);
        add_sample(32'd19999, 5);
        wait_drained();

        // Shortest span, no smoothing: saturation both ways.
        write_reg(REG_SPAN, 20'd1);
        write_reg(REG_SMOOTH, 20'd0);
        add_sample(32'h8000_0000, -32768);
        add_sample(32'h8000_0001, 32767);
        add_sample(32'h8000_0002, -32768);
        add_sample(32'h8000_0002, 0);
        add_sample(32'h0000_0002, 1);
        add_sample(32'h0000_0003, 1);
        wait_drained();

        // Zero span: the anchor is the new sample itself, so nothing is fresh.
        write_reg(REG_SPAN, 20'd0);
        add_sample(32'd5000, 1234);
        add_sample(32'd9000, -1234);
        add_sample(32'd9000, 77);
        wait_drained();

        // Default settings at full rate, with a long hold-off and a drain pause.
        write_reg(REG_SPAN, 20'd20000);
        write_reg(REG_SMOOTH, 20'd2000);
        set_idling(0, 0);
        clock_ms = 32'd100000;
        queue_stream(60, 2);
        hold_requests++;
        queue_stream(20, 2);
        while (rise_expect_q.size() > 0 || pending_samples.size() > 0 || in_valid)
            @(posedge clk);
        queue_stream(50, 2);
        wait_drained();

        write_reg(REG_SPAN, 20'd500);
        write_reg(REG_SMOOTH, 20'd150);
        set_idling(80, 0);
        queue_stream(100, 2);
        wait_drained();

        // Largest values, with upper data bits set for the narrower register.
        write_reg(REG_SPAN, 20'hFFFFF);
        write_reg(REG_SMOOTH, 20'hFFFFF);
        set_idling(0, 80);
        clock_ms = 32'hFFFF_F000;
        queue_stream(80, 30);
        wait_drained();

        write_reg(REG_SPAN, 20'($urandom_range(1, 5000)));
        write_reg(REG_SMOOTH, 20'($urandom_range(0, 3000)));
        set_idling(28, 28);
        queue_stream(120, 3);
        wait_drained();

        write_reg(REG_SPAN, 20'd1);
        write_reg(REG_SMOOTH, 20'd0);
        set_idling(0, 0);
        queue_stream(60, 2);
        wait_drained();

        write_reg(REG_SPAN, 20'd3000);
        write_reg(REG_SMOOTH, 20'd60000);
        set_idling(28, 28);
        queue_stream(80, 3);
        wait_drained();

        repeat (1200) @(posedge clk);
        $display("Run covered %0d samples and %0d results, %0d of them freshly computed,",
                 samples_taken, rises_seen, fresh_seen);
        $display("over eight register settings and four idling patterns.");
        if (mismatches == 0 && rise_expect_q.size() == 0)
            $display("No mismatches found");
        else
        begin
            if (rise_expect_q.size() > 0)
                $display("%0d expected results never arrived", rise_expect_q.size());
            $display("Mismatches found");
        end
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #16000000;
        $display("Timeout with %0d results outstanding", rise_expect_q.size());
        $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
